>>> rtl/pms_pkg.sv
`timescale 1ns / 1ps
package pms_pkg;
    localparam int VALUE_BITS_DEFAULT = 48;
    localparam int STEP_BITS_DEFAULT  = 16;
    localparam int CFG_INDEX_BITS     = 2;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_PROBE_STEP_0 = 2'd0,
        REG_PROBE_STEP_1 = 2'd1,
        REG_PROBE_STEP_2 = 2'd2,
        REG_FALLBACK     = 2'd3
    } cfg_reg_t;

    localparam logic [15:0] PROBE_STEP_0_RESET = 16'd0;
    localparam logic [15:0] PROBE_STEP_1_RESET = 16'd9830;
    localparam logic [15:0] PROBE_STEP_2_RESET = 16'd19661;
    localparam logic [15:0] FALLBACK_RESET     = 16'd5243;
endpackage

>>> rtl/pms_divider.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per stage, STEP_BITS stages.
// Operands are known to satisfy 0 <= num <= den * (2^STEP_BITS - 1).
module pms_divider #(
    parameter int STEP_BITS = pms_pkg::STEP_BITS_DEFAULT,
    parameter int DEN_BITS  = 80
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   advance,
    input  logic                   in_valid,
    input  logic [DEN_BITS+STEP_BITS-1:0] in_num,
    input  logic [DEN_BITS-1:0]    in_den,
    input  logic                   in_fallback,
    input  logic [STEP_BITS-1:0]   in_fallback_step,
    output logic                   out_valid,
    output logic [STEP_BITS-1:0]   out_step,
    output logic                   out_fallback
);
    localparam int NB = DEN_BITS + STEP_BITS;

    logic                 valid_reg    [STEP_BITS+1];
    logic [NB-1:0]        rem_reg      [STEP_BITS+1];
    logic [DEN_BITS-1:0]  den_reg      [STEP_BITS+1];
    logic [STEP_BITS-1:0] q_reg        [STEP_BITS+1];
    logic                 fb_reg       [STEP_BITS+1];
    logic [STEP_BITS-1:0] fbstep_reg   [STEP_BITS+1];

    assign valid_reg[0]  = in_valid;
    assign rem_reg[0]    = in_num;
    assign den_reg[0]    = in_den;
    assign q_reg[0]      = '0;
    assign fb_reg[0]     = in_fallback;
    assign fbstep_reg[0] = in_fallback_step;

    for (genvar k = 0; k < STEP_BITS; k++) begin : g_stage
        localparam int SH = STEP_BITS - 1 - k;
        logic [NB:0] shifted;
        logic        take;
        assign shifted = {1'b0, {{STEP_BITS{1'b0}}, den_reg[k]} << SH};
        assign take    = {1'b0, rem_reg[k]} >= shifted;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[k+1] <= 1'b0;
            else if (advance)
                valid_reg[k+1] <= valid_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                rem_reg[k+1]    <= take ? rem_reg[k] - shifted[NB-1:0] : rem_reg[k];
                q_reg[k+1]      <= q_reg[k] | (take ? STEP_BITS'(1) << SH : '0);
                den_reg[k+1]    <= den_reg[k];
                fb_reg[k+1]     <= fb_reg[k];
                fbstep_reg[k+1] <= fbstep_reg[k];
            end
        end
    end

    assign out_valid    = valid_reg[STEP_BITS];
    assign out_fallback = fb_reg[STEP_BITS];
    assign out_step     = fb_reg[STEP_BITS] ? fbstep_reg[STEP_BITS] : q_reg[STEP_BITS];
endmodule

>>> rtl/parabolic_minimum_step.sv
`timescale 1ns / 1ps
// Parabolic minimum step: one transaction per cycle while no stall holds the
// pipeline; each result passes through four stages for the products, the partial
// sums, the sign normalization and the range test, and then a restoring divider
// that resolves one quotient bit per stage. When the probe steps repeat, the
// curvature is zero or the vertex falls outside probe step 0 to probe step 2,
// the fallback step is returned with used_fallback set. A stall holds the whole
// pipeline.
module parabolic_minimum_step #(
    parameter int VALUE_BITS = pms_pkg::VALUE_BITS_DEFAULT,
    parameter int STEP_BITS  = pms_pkg::STEP_BITS_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [pms_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [STEP_BITS-1:0]        cfg_data,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic signed [VALUE_BITS-1:0] value_at_probe_0,
    input  logic signed [VALUE_BITS-1:0] value_at_probe_1,
    input  logic signed [VALUE_BITS-1:0] value_at_probe_2,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [STEP_BITS-1:0]        best_step,
    output logic                        used_fallback
);
    localparam int DW = STEP_BITS + 2;              // signed step difference
    localparam int PW = VALUE_BITS + DW;            // A, B, C
    localparam int SW = PW + 2;                     // sums of products
    localparam int NW = SW + STEP_BITS + 3;         // numerator
    localparam int DEN_W = SW + 1;                  // |D| magnitude
    localparam int BW = DEN_W + STEP_BITS + 1;      // bounds

    logic advance;
    assign advance  = !(out_valid && out_stall);
    assign in_stall = !advance;
    assign cfg_ready = 1'b1;

    logic [STEP_BITS-1:0] s0_reg, s1_reg, s2_reg, fb_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_reg <= STEP_BITS'(pms_pkg::PROBE_STEP_0_RESET);
            s1_reg <= STEP_BITS'(pms_pkg::PROBE_STEP_1_RESET);
            s2_reg <= STEP_BITS'(pms_pkg::PROBE_STEP_2_RESET);
            fb_reg <= STEP_BITS'(pms_pkg::FALLBACK_RESET);
        end
        else if (cfg_valid)
        begin
            case (pms_pkg::cfg_reg_t'(cfg_index))
                pms_pkg::REG_PROBE_STEP_0: s0_reg <= cfg_data;
                pms_pkg::REG_PROBE_STEP_1: s1_reg <= cfg_data;
                pms_pkg::REG_PROBE_STEP_2: s2_reg <= cfg_data;
                pms_pkg::REG_FALLBACK:     fb_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    logic signed [DW-1:0] s0, s1, s2, d01, d02, d12;
    assign s0  = DW'(s0_reg);
    assign s1  = DW'(s1_reg);
    assign s2  = DW'(s2_reg);
    assign d01 = s0 - s1;
    assign d02 = s2 - s0;   // already negated for B
    assign d12 = s1 - s2;
    logic bad_steps;
    assign bad_steps = (d01 == 0) || (d02 == 0) || (d12 == 0);

    // stage 1: A, B, C
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic signed [PW-1:0] a_reg, b_reg, c_reg;
    logic fb1_reg;
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            a_reg   <= PW'(value_at_probe_0) * PW'(d12);
            b_reg   <= PW'(value_at_probe_1) * PW'(d02);
            c_reg   <= PW'(value_at_probe_2) * PW'(d01);
            fb1_reg <= bad_steps;
        end
    end

    // stage 2: numerator partial products and denominator
    logic signed [NW-1:0] n0_reg, n1_reg, n2_reg;
    logic signed [SW-1:0] d_reg;
    logic fb2_reg;
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            n0_reg  <= NW'(SW'(b_reg) + SW'(c_reg)) * NW'(s0);
            n1_reg  <= NW'(SW'(a_reg) + SW'(c_reg)) * NW'(s1);
            n2_reg  <= NW'(SW'(a_reg) + SW'(b_reg)) * NW'(s2);
            d_reg   <= SW'(a_reg) + SW'(b_reg) + SW'(c_reg);
            fb2_reg <= fb1_reg;
        end
    end

    // stage 3: sum numerator, normalize sign so the denominator is positive
    logic signed [NW-1:0] num_sum;
    logic signed [NW:0]   num3_reg;
    logic [DEN_W-1:0]     den3_reg;
    logic fb3_reg;
    assign num_sum = n0_reg + n1_reg + n2_reg;
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            num3_reg <= d_reg[SW-1] ? -(NW+1)'(num_sum) : (NW+1)'(num_sum);
            den3_reg <= d_reg[SW-1] ? DEN_W'(-(SW+1)'(d_reg)) << 1
                                    : DEN_W'(d_reg) << 1;
            fb3_reg  <= fb2_reg || (d_reg == 0);
        end
    end

    // stage 4: range test against den*s0 and den*s2
    logic signed [BW:0] low_b, high_b;
    logic signed [NW+1:0] num_x;
    logic out_range;
    assign low_b  = $signed((BW+1)'(den3_reg)) * $signed((BW+1)'(s0_reg));
    assign high_b = $signed((BW+1)'(den3_reg)) * $signed((BW+1)'(s2_reg));
    assign num_x  = (NW+2)'(num3_reg);
    assign out_range = ((NW+BW+2)'(num_x) < (NW+BW+2)'(low_b)) ||
                       ((NW+BW+2)'(num_x) > (NW+BW+2)'(high_b));

    logic [DEN_W+STEP_BITS-1:0] num4_reg;
    logic [DEN_W-1:0]           den4_reg;
    logic fb4_reg;
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            num4_reg <= (DEN_W+STEP_BITS)'(num3_reg);
            den4_reg <= den3_reg;
            fb4_reg  <= fb3_reg || out_range;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    pms_divider #(
        .STEP_BITS (STEP_BITS),
        .DEN_BITS  (DEN_W)
    ) u_div (
        .clk              (clk),
        .rst_n            (rst_n),
        .advance          (advance),
        .in_valid         (v4_reg),
        .in_num           (fb4_reg ? '0 : num4_reg),
        .in_den           (den4_reg),
        .in_fallback      (fb4_reg),
        .in_fallback_step (fb_reg),
        .out_valid        (out_valid),
        .out_step         (best_step),
        .out_fallback     (used_fallback)
    );

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped under stall");
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall == (out_valid && out_stall))
        else $error("input stall mismatch");
    a_bad_steps: assert property (@(posedge clk) disable iff (!rst_n)
        advance && bad_steps |=> fb1_reg)
        else $error("equal steps not flagged");
endmodule
